// File: rtl/gwms_pkg.sv
// ----------------------------------------------------------------------------
// gwms_pkg: shared types and constants of the gated window mean/stddev block
// Field widths, configuration register indexes, the sequencer states and the
// control and status bundles of the shared divide / square root unit.
// ----------------------------------------------------------------------------
package gwms_pkg;

  localparam int HALF_WINDOW_MAX_DEF = 16;

  localparam int POS_W      = 16;
  localparam int CHG_W      = 16;
  localparam int MAXD_W     = 16;
  localparam int HW_W       = 5;
  localparam int TRACK_W    = 16;
  localparam int RING_W     = POS_W + CHG_W;
  localparam int IN_DATA_W  = POS_W + CHG_W;
  localparam int OUT_DATA_W = POS_W + 2 * CHG_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW  = 2'd1;

  localparam logic [MAXD_W-1:0] MAX_DISTANCE_RST = 16'd32;
  localparam logic [HW_W-1:0]   HALF_WINDOW_RST  = 5'd10;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } ds_op_t;

  typedef struct packed {
    logic   start;
    ds_op_t op;
  } ds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_CENTER,
    S_CPOS,
    S_SCAN,
    S_DRAIN,
    S_MUL,
    S_VAR,
    S_VWAIT,
    S_SWAIT,
    S_MWAIT,
    S_OUT
  } seq_state_t;

endpackage

// File: rtl/gwms_divsqrt.sv
// ----------------------------------------------------------------------------
// gwms_divsqrt: shared bit-serial divider and square root unit
// One subtract-and-compare datapath, used either for restoring division
// (one quotient bit per cycle) or digit-by-digit square root (one root bit
// per cycle).
// ----------------------------------------------------------------------------
module gwms_divsqrt #(
  parameter int VW = 44,
  parameter int DW = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gwms_pkg::ds_ctrl_t ctrl,
  input  logic [VW-1:0]      num,
  input  logic [DW-1:0]      den,
  output gwms_pkg::ds_stat_t stat,
  output logic [VW-1:0]      result
);
  import gwms_pkg::*;

  localparam int RTW   = VW / 2;
  localparam int SUBW  = RTW + 3;
  localparam int CNT_W = $clog2(VW + 1);

  ds_op_t           op_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0]    work_r, work_nxt;
  logic [SUBW-1:0]  rem_r, rem_nxt;
  logic [VW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    den_r;
  logic [SUBW-1:0]  opa, opb;
  logic [SUBW:0]    diff;
  logic             ge;

  // In root mode the partial root lives in the low bits of the quotient.
  always_comb begin
    case (op_r)
      DS_SQRT: begin
        opa = {rem_r[SUBW-3:0], work_r[VW-1:VW-2]};
        opb = {1'b0, quo_r[RTW-1:0], 2'b01};
      end
      default: begin
        opa = {rem_r[SUBW-2:0], work_r[VW-1]};
        opb = {{(SUBW-DW){1'b0}}, den_r};
      end
    endcase
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[SUBW];
  end

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    if (ctrl.start) begin
      work_nxt = num;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = (ctrl.op == DS_SQRT) ? CNT_W'(RTW) : CNT_W'(VW);
    end else if (busy_r) begin
      work_nxt = (op_r == DS_SQRT) ? {work_r[VW-3:0], 2'b00} : {work_r[VW-2:0], 1'b0};
      rem_nxt  = ge ? diff[SUBW-1:0] : opa;
      quo_nxt  = {quo_r[VW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= DS_DIV;
    end else begin
      busy_r <= ctrl.start | (busy_r && (cnt_r != CNT_W'(1)));
      done_r <= !ctrl.start && busy_r && (cnt_r == CNT_W'(1));
      if (ctrl.start) begin
        op_r <= ctrl.op;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    if (ctrl.start) begin
      den_r <= den;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = quo_r;

endmodule

// File: rtl/gated_window_mean_stddev.sv
// ----------------------------------------------------------------------------
// gated_window_mean_stddev: gated sliding-window charge mean and spread
// For each point of a track, the mean and standard deviation of the charge
// of neighbouring points that lie within a half-window and a distance gate.
// ----------------------------------------------------------------------------
// Usage. Points of a track stream in on the in_ channel, one word per point;
// in_tlast marks the last point of a track. Each result word on the out_
// channel belongs to one centre point, in point order, and out_tlast is set
// on the result of the track's last point. Results lag the input by the
// half-window: a point releases the centre half_window points behind it, and
// the track's last point releases every centre still pending.
// Timing. A point is accepted in S_IDLE and S_SETUP then decides what it
// releases; a point that releases nothing goes back to S_IDLE, ready again.
// Each released result scans N neighbours (at most 2*half_window+1, one
// ring read per cycle) and then runs two divisions and one root on the
// bit-serial divide / root unit, VW = 32 + 2*ceil(log2(2*HALF_WINDOW_MAX+2))
// bits wide. in_tready is low while results are being computed. The last
// result sits in an output register, so a new point is taken while it
// waits; a stalled receiver holds up only the next result. Reset clears
// the sequencer, the track counters and the registers to their defaults;
// the point ring needs no clearing, since only entries written in the
// current track are read. cfg_ready is always high; configuration is meant
// to be written while the block is idle.
module gated_window_mean_stddev #(
  parameter int HALF_WINDOW_MAX = gwms_pkg::HALF_WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Point input.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] point_position, [31:16] charge_sample
  input  logic [gwms_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,   // track_end
  // Result output.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] out_position, [31:16] mean_charge, [47:32] charge_spread
  output logic [gwms_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,  // track_end_out
  // Register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gwms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gwms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gwms_pkg::*;

  localparam int DEPTH = 2 * HALF_WINDOW_MAX + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int HWW   = $clog2(HALF_WINDOW_MAX + 1);
  localparam int S1W   = CHG_W + NW;
  localparam int S2W   = 2 * CHG_W + NW;
  localparam int SQW   = 2 * CHG_W;
  localparam int VW    = 2 * CHG_W + 2 * NW;
  localparam int DW    = 2 * NW;
  localparam int CW    = TRACK_W + 1;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    ring_inc = (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  // Sequencer and configuration.
  seq_state_t          state_r, state_nxt;
  logic [MAXD_W-1:0]   max_dist_r;
  logic [HW_W-1:0]     half_win_r;

  // Track bookkeeping: ring slots follow the point indexes modulo DEPTH.
  logic [TRACK_W-1:0]  pit_r;
  logic [TRACK_W-1:0]  nc_r;
  logic [AW-1:0]       wr_idx_r;
  logic [AW-1:0]       ctr_idx_r;
  logic [CW-1:0]       count_r;
  logic                end_r;

  // Point ring, one write and one registered read per cycle.
  logic [RING_W-1:0]   ring_mem [DEPTH];
  logic [AW-1:0]       rd_addr;
  logic [RING_W-1:0]   rd_data_r;
  logic                rd_vld_r;

  // Neighbour scan and accumulation.
  logic [POS_W-1:0]    cpos_r;
  logic [AW-1:0]       scan_addr_r;
  logic [NW-1:0]       scan_left_r;
  logic                vld1_r;
  logic                take1_r;
  logic [CHG_W-1:0]    q1_r;
  logic [SQW-1:0]      sq1_r;
  logic [NW-1:0]       n_r;
  logic [S1W-1:0]      s1_r;
  logic [S2W-1:0]      s2_r;
  logic [VW-1:0]       pa_r;
  logic [VW-1:0]       pb_r;
  logic [DW-1:0]       nsq_r;
  logic [CHG_W-1:0]    spread_r;
  logic [CHG_W-1:0]    mean_r;

  // Result register.
  logic                out_vld_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [CHG_W-1:0]    out_mean_r;
  logic [CHG_W-1:0]    out_spread_r;
  logic                out_last_r;

  // Shared divide / root unit.
  ds_ctrl_t            ds_ctrl;
  ds_stat_t            ds_stat;
  logic [VW-1:0]       ds_num;
  logic [DW-1:0]       ds_den;
  logic [VW-1:0]       ds_result;

  // Control strobes.
  logic                in_acc;
  logic                scan_issue;
  logic                out_load;
  logic                finish_item;

  // Window arithmetic.
  logic [HWW-1:0]      hw_eff;
  logic [CW-1:0]       nc_ext;
  logic                emit_go;
  logic                last_c;
  logic [HWW-1:0]      n_before;
  logic [HWW-1:0]      n_after;
  logic [CW-1:0]       rest;
  logic [NW-1:0]       n_total;
  logic [AW-1:0]       scan_start;
  logic [POS_W-1:0]    rd_pos;
  logic [CHG_W-1:0]    rd_q;
  logic [POS_W-1:0]    gap;
  logic [VW-1:0]       var_num;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  // A half-window above the ring's reach acts as the largest one.
  assign hw_eff = (half_win_r > HW_W'(HALF_WINDOW_MAX)) ? HWW'(HALF_WINDOW_MAX)
                                                        : half_win_r[HWW-1:0];
  assign nc_ext = {1'b0, nc_r};

  // The next centre is due once its whole right half-window has arrived,
  // or once the track has ended.
  assign emit_go = (nc_ext < count_r) && (end_r || ((nc_ext + CW'(hw_eff)) < count_r));
  assign last_c  = end_r && ((nc_ext + 1'b1) == count_r);

  // Window bounds clipped to the points that exist in this track.
  assign n_before = (nc_r < TRACK_W'(hw_eff)) ? nc_r[HWW-1:0] : hw_eff;
  assign rest     = count_r - nc_ext - 1'b1;
  assign n_after  = (rest < CW'(hw_eff)) ? rest[HWW-1:0] : hw_eff;
  assign n_total  = NW'(n_before) + NW'(n_after) + 1'b1;
  assign scan_start = (ctr_idx_r >= AW'(n_before)) ? ctr_idx_r - AW'(n_before)
                                                   : ctr_idx_r + AW'(DEPTH) - AW'(n_before);

  assign rd_pos = rd_data_r[RING_W-1:CHG_W];
  assign rd_q   = rd_data_r[CHG_W-1:0];
  assign gap    = (rd_pos > cpos_r) ? rd_pos - cpos_r : cpos_r - rd_pos;

  // n*S2 >= S1*S1 always holds in exact integers; the clamp is kept anyway.
  assign var_num = (pa_r > pb_r) ? pa_r - pb_r : '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_SETUP;
      S_SETUP:  state_nxt = emit_go ? S_CENTER : S_IDLE;
      S_CENTER: state_nxt = S_CPOS;
      S_CPOS:   state_nxt = S_SCAN;
      S_SCAN:   if (scan_left_r == NW'(1)) state_nxt = S_DRAIN;
      S_DRAIN:  if (!rd_vld_r && !vld1_r) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_VAR;
      S_VAR:    state_nxt = S_VWAIT;
      S_VWAIT:  if (ds_stat.done) state_nxt = S_SWAIT;
      S_SWAIT:  if (ds_stat.done) state_nxt = S_MWAIT;
      S_MWAIT:  if (ds_stat.done) state_nxt = S_OUT;
      S_OUT:    if (!out_vld_r || out_tready) state_nxt = S_SETUP;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready   = 1'b0;
    scan_issue  = 1'b0;
    out_load    = 1'b0;
    finish_item = 1'b0;
    rd_addr     = ctr_idx_r;
    ds_ctrl     = '{start: 1'b0, op: DS_DIV};
    ds_num      = var_num;
    ds_den      = nsq_r;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_SETUP: finish_item = !emit_go;
      S_SCAN: begin
        scan_issue = 1'b1;
        rd_addr    = scan_addr_r;
      end
      S_VAR: ds_ctrl = '{start: 1'b1, op: DS_DIV};
      S_VWAIT: begin
        ds_ctrl = '{start: ds_stat.done, op: DS_SQRT};
        ds_num  = ds_result;
      end
      S_SWAIT: begin
        ds_ctrl = '{start: ds_stat.done, op: DS_DIV};
        ds_num  = VW'(s1_r);
        ds_den  = DW'(n_r);
      end
      S_OUT: out_load = !out_vld_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      max_dist_r <= MAX_DISTANCE_RST;
      half_win_r <= HALF_WINDOW_RST;
      pit_r      <= '0;
      nc_r       <= '0;
      wr_idx_r   <= '0;
      ctr_idx_r  <= '0;
      rd_vld_r   <= 1'b0;
      vld1_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= scan_issue;
      vld1_r   <= rd_vld_r;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_DISTANCE) begin
          max_dist_r <= cfg_data[MAXD_W-1:0];
        end else if (cfg_index == REG_HALF_WINDOW) begin
          half_win_r <= cfg_data[HW_W-1:0];
        end
      end

      if (in_acc) begin
        wr_idx_r <= ring_inc(wr_idx_r);
      end

      if (out_load) begin
        nc_r      <= nc_r + 1'b1;
        ctr_idx_r <= ring_inc(ctr_idx_r);
      end

      // A finished track restarts the point numbering.
      if (finish_item) begin
        if (end_r) begin
          pit_r     <= '0;
          nc_r      <= '0;
          wr_idx_r  <= '0;
          ctr_idx_r <= '0;
        end else begin
          pit_r <= count_r[TRACK_W-1:0];
        end
      end

      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Point ring. Each entry keeps the position in its high half and the
  // charge in its low half.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_mem[wr_idx_r] <= {in_tdata[POS_W-1:0], in_tdata[IN_DATA_W-1:POS_W]};
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      count_r <= CW'(pit_r) + 1'b1;
      // The point with the highest index ends its track regardless.
      end_r   <= in_tlast | (pit_r == '1);
    end

    if (state_r == S_SETUP) begin
      scan_addr_r <= scan_start;
      scan_left_r <= n_total;
    end else if (scan_issue) begin
      scan_addr_r <= ring_inc(scan_addr_r);
      scan_left_r <= scan_left_r - 1'b1;
    end

    if (state_r == S_CPOS) begin
      cpos_r <= rd_pos;
    end

    // Gate stage: distance test and square, one neighbour per cycle.
    take1_r <= (gap <= max_dist_r);
    q1_r    <= rd_q;
    sq1_r   <= SQW'(rd_q) * SQW'(rd_q);

    if (state_r == S_CENTER) begin
      n_r  <= '0;
      s1_r <= '0;
      s2_r <= '0;
    end else if (vld1_r && take1_r) begin
      n_r  <= n_r + 1'b1;
      s1_r <= s1_r + S1W'(q1_r);
      s2_r <= s2_r + S2W'(sq1_r);
    end

    // Variance numerator and denominator: (n*S2 - S1*S1) / (n*n).
    if (state_r == S_MUL) begin
      pa_r  <= VW'(n_r) * VW'(s2_r);
      pb_r  <= VW'(s1_r) * VW'(s1_r);
      nsq_r <= DW'(n_r) * DW'(n_r);
    end

    if (state_r == S_SWAIT && ds_stat.done) begin
      spread_r <= ds_result[CHG_W-1:0];
    end
    if (state_r == S_MWAIT && ds_stat.done) begin
      mean_r <= ds_result[CHG_W-1:0];
    end

    if (out_load) begin
      out_pos_r    <= cpos_r;
      out_mean_r   <= mean_r;
      out_spread_r <= spread_r;
      out_last_r   <= last_c;
    end
  end

  gwms_divsqrt #(
    .VW (VW),
    .DW (DW)
  ) u_divsqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ds_ctrl),
    .num    (ds_num),
    .den    (ds_den),
    .stat   (ds_stat),
    .result (ds_result)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_spread_r, out_mean_r, out_pos_r};
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/gwms_checker.sv
// ----------------------------------------------------------------------------
// gwms_checker: port-level checks of the gated window mean/stddev block
// Watches the stream ports over time and reports violations.
// ----------------------------------------------------------------------------
module gwms_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gwms_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import gwms_pkg::*;

  // A result word waits until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Each accepted point is processed before the next one is taken.
  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("two points accepted in consecutive cycles");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind gated_window_mean_stddev gwms_checker u_gwms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: sim/tb_gated_window_mean_stddev.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gated_window_mean_stddev: self-checking bench for the windowed charge stats
// Streams track points into the block, keeps its own model of the point
// history and the window arithmetic, and checks every result word field by
// field, under random bursts, receiver stalls and register changes.
// ----------------------------------------------------------------------------

localparam int WIN_CAP    = gwms_pkg::HALF_WINDOW_MAX_DEF;
localparam int HIST_DEPTH = 2 * WIN_CAP + 1;

typedef struct packed {
  logic [15:0] position;
  logic [15:0] mean;
  logic [15:0] spread;
  logic        last;
} charge_stats_t;

// Tracks the expected result words and compares the ones the block sends.
class charge_scoreboard;
  logic [31:0]   hist [HIST_DEPTH];   // {position, charge} per point
  int unsigned   trk_len;             // points taken in the open track
  int unsigned   rep_idx;             // next centre still to be reported
  logic [15:0]   gate_dist;
  logic [4:0]    win_half;
  charge_stats_t expected_stats [$];
  int            errors;
  int            checked;

  function new();
    foreach (hist[i]) hist[i] = '0;
    trk_len   = 0;
    rep_idx   = 0;
    gate_dist = gwms_pkg::MAX_DISTANCE_RST;
    win_half  = gwms_pkg::HALF_WINDOW_RST;
    errors    = 0;
    checked   = 0;
  endfunction

  function void write_reg(logic [gwms_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    if (idx == gwms_pkg::REG_MAX_DISTANCE) begin
      gate_dist = data;
    end else if (idx == gwms_pkg::REG_HALF_WINDOW) begin
      win_half = data[4:0];
    end
  endfunction

  // Floor of the square root, one result bit at a time from the top.
  function logic [31:0] int_sqrt(logic [63:0] x);
    logic [31:0] r;
    logic [31:0] cand;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (32'd1 << b);
      if (64'(cand) * 64'(cand) <= x) r = cand;
    end
    return r;
  endfunction

  function charge_stats_t center_stats(int c, int w, int cnt, bit last);
    logic [15:0]   cpos;
    logic [15:0]   pos;
    logic [15:0]   q;
    logic [15:0]   gap;
    logic [63:0]   n;
    logic [63:0]   s1;
    logic [63:0]   s2;
    logic [63:0]   var_num;
    int            lo;
    int            hi;
    charge_stats_t r;
    cpos = hist[c % HIST_DEPTH][31:16];
    n  = '0;
    s1 = '0;
    s2 = '0;
    lo = (c >= w) ? c - w : 0;
    hi = c + w;
    if (hi > cnt - 1) hi = cnt - 1;
    for (int j = lo; j <= hi; j++) begin
      pos = hist[j % HIST_DEPTH][31:16];
      q   = hist[j % HIST_DEPTH][15:0];
      gap = (pos > cpos) ? pos - cpos : cpos - pos;
      if (gap <= gate_dist) begin
        n  = n + 1;
        s1 = s1 + 64'(q);
        s2 = s2 + 64'(q) * 64'(q);
      end
    end
    r.position = cpos;
    r.last     = last;
    if (n == 0) begin
      r.mean   = '0;
      r.spread = '0;
    end else begin
      var_num  = (n * s2 > s1 * s1) ? (n * s2 - s1 * s1) / (n * n) : '0;
      r.mean   = 16'(s1 / n);
      r.spread = 16'(int_sqrt(var_num));
    end
    return r;
  endfunction

  // An accepted point releases every centre whose window is now complete.
  function void note_point(logic [15:0] pos, logic [15:0] chg, logic last);
    int unsigned   cnt;
    int unsigned   w;
    bit            ends;
    charge_stats_t st;
    hist[trk_len % HIST_DEPTH] = {pos, chg};
    cnt  = trk_len + 1;
    ends = last;
    if (cnt >= 65536) ends = 1'b1;
    w = (win_half > WIN_CAP) ? WIN_CAP : win_half;
    while (rep_idx < cnt && (ends || rep_idx + w < cnt)) begin
      st = center_stats(rep_idx, w, cnt, ends && rep_idx + 1 == cnt);
      expected_stats = {expected_stats, st};
      rep_idx++;
    end
    if (ends) begin
      trk_len = 0;
      rep_idx = 0;
    end else begin
      trk_len = cnt;
    end
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(logic [gwms_pkg::OUT_DATA_W-1:0] data, logic last);
    charge_stats_t want;
    checked++;
    if (expected_stats.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word: expected none, actual %h last %b",
               $time, data, last);
      return;
    end
    want = expected_stats.pop_front();
    compare_field("out_position", want.position, data[15:0]);
    compare_field("mean_charge", want.mean, data[31:16]);
    compare_field("charge_spread", want.spread, data[47:32]);
    compare_field("track_end_out", 16'(want.last), 16'(last));
  endfunction

  function int pending();
    return expected_stats.size();
  endfunction
endclass

module tb_gated_window_mean_stddev;
  import gwms_pkg::*;

  localparam int ITEM_TARGET   = 410;
  // The long receiver hold-off starts once this many results have been checked.
  localparam int HOLD_AFTER    = 60;
  localparam int HOLD_CYCLES   = 700;
  // A point that releases no result is done once S_SETUP has run, so a short
  // settle after the last result is enough before touching registers.
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 200;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_MAX_DISTANCE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_ready;

  charge_scoreboard sb;
  int               items_sent = 0;
  int               burst_left = 0;

  always #10 clk = ~clk;

  gated_window_mean_stddev u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] point_position, [31:16] charge_sample
    .in_tlast   (in_tlast),    // track_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [15:0] position, [31:16] mean, [47:32] spread
    .out_tlast  (out_tlast),   // track_end_out
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // All handshakes are observed here, on the values that stood before the
  // edge. Results are checked before a point taken at the same edge is
  // modeled, so a word can never be matched against its own cause.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_point(in_tdata[15:0], in_tdata[31:16], in_tlast);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Offers one point and waits for it to be taken. The sender runs in bursts;
  // when a burst is used up it may rest for a few cycles. A zero-length rest
  // keeps in_tvalid high straight into the next word, so valid is never
  // lowered and raised again in the same step.
  task automatic push_point(input logic [15:0] pos, input logic [15:0] chg,
                            input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {chg, pos};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48)
                                               : $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Lets every expected result come out, then a few more cycles so that a
  // point which releases nothing has surely been absorbed. The first edge
  // lets the monitor log a point taken at the edge just passed.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the distance gate, then the half-window, back to back.
  task automatic set_regs(input logic [15:0] gate_val, input logic [15:0] win);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAX_DISTANCE;
    cfg_data  <= gate_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_HALF_WINDOW;
    cfg_data  <= win;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One track of random content. Positions mostly creep forward in small
  // steps, so the distance gate cuts some neighbours and keeps others, with
  // an occasional jump anywhere. Charges are either flat noise or cluster
  // around a base value, with now and then a full-scale extreme.
  task automatic run_track(input int len, input bit close);
    logic [15:0] pos;
    logic [15:0] base;
    logic [15:0] chg;
    int          step_max;
    int          mode;
    pos      = 16'($urandom);
    base     = 16'($urandom);
    mode     = $urandom_range(0, 2);
    step_max = ($urandom_range(0, 1) == 0) ? 8 : 64;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) pos = 16'($urandom);
      else pos = pos + 16'($urandom_range(0, step_max));
      if ($urandom_range(0, 15) == 0) chg = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      else if (mode == 0) chg = 16'($urandom);
      else if (mode == 1) chg = base + 16'($urandom_range(0, 255));
      else chg = base ^ 16'($urandom_range(0, 4095));
      push_point(pos, chg, close && i == len - 1);
    end
  endtask

  // Receiver: ready steps through a random 8-bit mask that is redrawn periodically;
  // a third of the masks are all ones. Once, while the sender is busy, the
  // receiver holds off for a long stretch so the output register fills, the
  // next result backs up behind it and the block has to stall its input.
  initial begin
    int         cyc;
    bit         held;
    logic [7:0] mask;
    cyc  = 0;
    held = 1'b0;
    mask = 8'hFF;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) begin
        if ($urandom_range(0, 2) == 0) mask = 8'hFF;
        else mask = 8'($urandom) | (8'h01 << $urandom_range(0, 7));
      end
      if (!held && sb.checked >= HOLD_AFTER && in_tvalid) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= mask[cyc % 8];
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("tb_gated_window_mean_stddev: FAIL");
    $finish;
  end

  initial begin
    logic [15:0] gate_val;
    logic [15:0] win;
    int          ntr;
    int          len;
    bit          close;
    bit          open_trk;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of the registers: gate 32, half-window 10. The middle
    // point sees the first one but not the last.
    push_point(16'd100, 16'd500, 1'b0);
    push_point(16'd120, 16'd700, 1'b0);
    push_point(16'd160, 16'd900, 1'b1);
    settle();

    // Widest gate, half-window 2: neighbours fall off both ends of the track,
    // and positions and charges hit zero and full scale.
    set_regs(16'hFFFF, 16'd2);
    push_point(16'h0000, 16'h0000, 1'b0);
    push_point(16'hFFFF, 16'hFFFF, 1'b0);
    push_point(16'h8000, 16'hFFFF, 1'b0);
    push_point(16'h0001, 16'h0000, 1'b0);
    push_point(16'hFFFF, 16'h5555, 1'b1);
    // A track of a single point.
    push_point(16'h1234, 16'hFFFF, 1'b1);
    settle();

    // Zero gate: only points at exactly the same position count.
    set_regs(16'h0000, 16'd1);
    push_point(16'd7, 16'd1, 1'b0);
    push_point(16'd7, 16'd3, 1'b0);
    push_point(16'd8, 16'd5, 1'b1);
    settle();

    // A half-window above the cap acts as the cap; alternating extremes give
    // the largest spread.
    set_regs(16'hFFFF, 16'd31);
    push_point(16'd10, 16'h0000, 1'b0);
    push_point(16'd20, 16'hFFFF, 1'b0);
    push_point(16'd30, 16'h0000, 1'b0);
    push_point(16'd40, 16'hFFFF, 1'b1);
    settle();

    // Half-window shrinks in the middle of a track: the next point releases
    // every centre the new value allows in one burst. The write carries junk
    // above the five register bits.
    set_regs(16'd64, 16'd6);
    for (int i = 0; i < 8; i++) push_point(16'(300 + 10 * i), 16'(1000 + 37 * i), 1'b0);
    settle();
    set_regs(16'd64, {11'h7FF, 5'd1});
    push_point(16'd380, 16'd2000, 1'b0);
    push_point(16'd390, 16'd2100, 1'b1);

    // Random phases: new registers, then one to three tracks. Sometimes the
    // last track is left open, so the next register write lands mid-track.
    open_trk = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 4))
        0:       gate_val = 16'h0000;
        1:       gate_val = 16'hFFFF;
        2:       gate_val = 16'($urandom_range(0, 16));
        3:       gate_val = 16'($urandom_range(16, 200));
        default: gate_val = 16'($urandom);
      endcase
      case ($urandom_range(0, 6))
        0:       win = 16'd0;
        1:       win = 16'd16;
        2:       win = 16'd31;
        3:       win = 16'($urandom_range(17, 31));
        default: win = 16'($urandom_range(0, 16));
      endcase
      if ($urandom_range(0, 1) == 0) win[15:5] = 11'($urandom);
      set_regs(gate_val, win);
      ntr = $urandom_range(1, 3);
      for (int t = 0; t < ntr; t++) begin
        len   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        close = !(t == ntr - 1 && $urandom_range(0, 3) == 0);
        run_track(len, close);
        open_trk = !close;
      end
    end
    if (open_trk) push_point(16'($urandom), 16'($urandom), 1'b1);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_gated_window_mean_stddev: PASS");
    end else begin
      $display("tb_gated_window_mean_stddev: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gwms_pkg.sv
rtl/gwms_divsqrt.sv
rtl/gated_window_mean_stddev.sv
rtl/gwms_checker.sv
sim/tb_gated_window_mean_stddev.sv
